>>> src/dte_pkg.sv
// Shared constants, codes and types of the descriptor table engine.
`timescale 1ns / 1ps

package dte_pkg;

   localparam int TABLE_DEPTH       = 64;
   localparam int HANDLE_BITS       = 16;

   // The handle field is 16 bits wide, so no stored handle is ever wider.
   localparam int HANDLE_STORE_BITS = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
   localparam int IDX_BITS          = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS        = $clog2(TABLE_DEPTH + 1);

   // Free-slot search examines one group of lanes per cycle.
   localparam int SCAN_BITS         = 3;
   localparam int SCAN_LANES        = 1 << SCAN_BITS;
   localparam int GROUP_COUNT       = (TABLE_DEPTH + SCAN_LANES - 1) / SCAN_LANES;
   localparam int GROUP_BITS        = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int CAND_BITS         = GROUP_BITS + SCAN_BITS;

   // Fixed widths of the result fields.
   localparam int SLOT_OUT_BITS     = 6;
   localparam int HANDLE_OUT_BITS   = 16;
   localparam int COUNT_OUT_BITS    = 7;

   localparam logic [2:0] ACT_ALLOC      = 3'd0;
   localparam logic [2:0] ACT_LOOKUP     = 3'd1;
   localparam logic [2:0] ACT_CLOSE      = 3'd2;
   localparam logic [2:0] ACT_DUP        = 3'd3;
   localparam logic [2:0] ACT_RD_FLAG    = 3'd4;
   localparam logic [2:0] ACT_WR_FLAG    = 3'd5;
   localparam logic [2:0] ACT_CLOSE_ALL  = 3'd6;
   localparam logic [2:0] ACT_CLOSE_FLAG = 3'd7;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVAL    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_BAD_SLOT = 2'd3;

   typedef struct packed {
      logic [HANDLE_STORE_BITS-1:0] handle;
      logic                         exec_close;
   } entry_type;

   typedef struct packed {
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_addr;
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      entry_type           wr_data;
   } ram_req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic [SLOT_OUT_BITS-1:0]   result_slot;
      logic [HANDLE_OUT_BITS-1:0] result_handle;
      logic                       flag_out;
      logic                       add_reference;
      logic                       release_valid;
      logic [HANDLE_OUT_BITS-1:0] released_handle;
      logic [COUNT_OUT_BITS-1:0]  open_count;
      logic                       last;
   } rsp_type;

endpackage

>>> src/dte_channels.sv
// Request and response channel interfaces of the descriptor table engine.
`timescale 1ns / 1ps

interface dte_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        action;
   logic signed [7:0] slot;
   logic signed [7:0] target;
   logic [15:0]       handle;
   logic              flag_value;

   modport source (output valid, action, slot, target, handle, flag_value, input ready);
   modport sink   (input valid, action, slot, target, handle, flag_value, output ready);
endinterface

interface dte_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [5:0]  result_slot;
   logic [15:0] result_handle;
   logic        flag_out;
   logic        add_reference;
   logic        release_valid;
   logic [15:0] released_handle;
   logic [6:0]  open_count;
   logic        last;

   modport source (output valid, status, result_slot, result_handle, flag_out,
                   add_reference, release_valid, released_handle, open_count, last,
                   input ready);
   modport sink   (input valid, status, result_slot, result_handle, flag_out,
                   add_reference, release_valid, released_handle, open_count, last,
                   output ready);
endinterface

>>> src/dte_slot_ram.sv
// Slot table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module dte_slot_ram
   import dte_pkg::*;
(
   input  logic        clock,
   input  ram_req_type req,
   output entry_type   rd_data
);

   entry_type mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      // hold the read data until the next read is issued
      if (req.rd_en) begin
         rd_data <= mem[req.rd_addr];
      end
   end

endmodule

>>> src/dte_free_scan.sv
// Lowest free slot search over one group of slots at or above a floor.
`timescale 1ns / 1ps

module dte_free_scan
   import dte_pkg::*;
(
   input  logic [TABLE_DEPTH-1:0] occupied,
   input  logic [GROUP_BITS-1:0]  group_sel,
   input  logic [IDX_BITS-1:0]    floor_slot,
   output logic                   found,
   output logic [IDX_BITS-1:0]    found_slot
);

   logic [CAND_BITS-1:0]  pos;
   logic [SCAN_LANES-1:0] lane_free;

   always_comb begin
      pos = '0;
      for (int i = 0; i < SCAN_LANES; i++) begin
         pos = {group_sel, SCAN_BITS'(i)};
         lane_free[i] = (int'(pos) < TABLE_DEPTH) && (int'(pos) >= int'(floor_slot))
                        && !occupied[pos[IDX_BITS-1:0]];
      end
   end

   always_comb begin
      found      = 1'b0;
      found_slot = '0;
      for (int i = 0; i < SCAN_LANES; i++) begin
         if (lane_free[i] && !found) begin
            found      = 1'b1;
            found_slot = IDX_BITS'({group_sel, SCAN_BITS'(i)});
         end
      end
   end

endmodule

>>> src/descriptor_table_engine.sv
// Top level of the descriptor table engine: sequencer, occupancy map, result register.
//
// Usage: one request beat on req_ch carries an action and its operands; the engine
// answers on rsp_ch with one response beat, or for a sweep with one beat per released
// handle or a single beat when none is released, and marks the final beat of a request
// with last. req_ch.ready is high only while no request is in progress, so one request
// is worked at a time. A duplicate onto an occupied slot first reads the handle that
// the overwrite releases. The time of allocate and of duplicate to lowest free is set
// by the free-slot search, which examines eight slots per cycle; a sweep reads each
// occupied slot in turn through the single read port of the slot memory.
// Slot memory accesses of one request never overlap those of the next, so no forwarding
// is needed.
// Reset clears every slot at once through the occupancy map; the engine is ready for a
// request as soon as reset is released. A stalled response beat holds in the output
// register; the engine works ahead until it needs to emit the next beat, then waits.
`timescale 1ns / 1ps

module descriptor_table_engine
   import dte_pkg::*;
(
   input logic      clock,
   input logic      reset,
   dte_req_if.sink  req_ch,
   dte_rsp_if.source rsp_ch
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_RD_SRC = 3'd2;
   localparam logic [2:0] S_RD_TGT = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_SW_RD  = 3'd5;
   localparam logic [2:0] S_SW_CHK = 3'd6;
   localparam logic [2:0] S_SW_END = 3'd7;

   localparam logic [IDX_BITS-1:0]   LAST_IDX   = IDX_BITS'(TABLE_DEPTH - 1);
   localparam logic [GROUP_BITS-1:0] LAST_GROUP = GROUP_BITS'(GROUP_COUNT - 1);

   logic [2:0]                   state_ff, state_in;
   logic [2:0]                   act_ff, act_in;
   logic [7:0]                   src_ff, src_in;
   logic [7:0]                   tgt_ff, tgt_in;
   logic [HANDLE_STORE_BITS-1:0] hnd_ff, hnd_in;
   logic                         fv_ff, fv_in;
   logic [HANDLE_STORE_BITS-1:0] hsrc_ff, hsrc_in;
   logic [IDX_BITS-1:0]          floor_ff, floor_in;
   logic [GROUP_BITS-1:0]        grp_ff, grp_in;
   logic [IDX_BITS-1:0]          idx_ff, idx_in;
   logic [TABLE_DEPTH-1:0]       occ_ff, occ_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;
   logic                         pend_valid_ff, pend_valid_in;
   rsp_type                      pend_ff, pend_in;

   ram_req_type ram_req;
   entry_type   rd_data;
   logic        scan_found;
   logic [IDX_BITS-1:0] scan_slot;

   logic                emit;
   logic                fresh;
   rsp_type             emit_data;
   logic                out_free;
   logic [IDX_BITS-1:0] src_idx, tgt_idx;
   logic                src_in_range, tgt_in_range, src_ok;
   logic                sweep_release;

   dte_slot_ram u_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (rd_data)
   );

   dte_free_scan u_scan (
      .occupied   (occ_ff),
      .group_sel  (grp_ff),
      .floor_slot (floor_ff),
      .found      (scan_found),
      .found_slot (scan_slot)
   );

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign src_idx      = src_ff[IDX_BITS-1:0];
   assign tgt_idx      = tgt_ff[IDX_BITS-1:0];
   assign src_in_range = !src_ff[7] && (int'(src_ff[6:0]) < TABLE_DEPTH);
   assign tgt_in_range = !tgt_ff[7] && (int'(tgt_ff[6:0]) < TABLE_DEPTH);
   assign src_ok       = src_in_range && occ_ff[src_idx];
   assign sweep_release = (act_ff == ACT_CLOSE_ALL) || rd_data.exec_close;

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      src_in        = src_ff;
      tgt_in        = tgt_ff;
      hnd_in        = hnd_ff;
      fv_in         = fv_ff;
      hsrc_in       = hsrc_ff;
      floor_in      = floor_ff;
      grp_in        = grp_ff;
      idx_in        = idx_ff;
      occ_in        = occ_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      ram_req       = '0;
      emit          = 1'b0;
      fresh         = 1'b1;
      emit_data     = '0;
      emit_data.last = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               act_in   = req_ch.action;
               src_in   = req_ch.slot;
               tgt_in   = req_ch.target;
               hnd_in   = req_ch.handle[HANDLE_STORE_BITS-1:0];
               fv_in    = req_ch.flag_value;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            unique case (act_ff)
               ACT_ALLOC: begin
                  if (tgt_ff[7] || !tgt_in_range) begin
                     if (out_free) begin
                        emit             = 1'b1;
                        emit_data.status = tgt_ff[7] ? ST_INVAL : ST_FULL;
                        state_in         = S_IDLE;
                     end
                  end else begin
                     floor_in = tgt_idx;
                     grp_in   = GROUP_BITS'(tgt_idx >> SCAN_BITS);
                     state_in = S_SCAN;
                  end
               end
               ACT_CLOSE_ALL, ACT_CLOSE_FLAG: begin
                  idx_in   = '0;
                  state_in = S_SW_RD;
               end
               default: begin
                  if (!src_ok) begin
                     if (out_free) begin
                        emit             = 1'b1;
                        emit_data.status = ST_BAD_SLOT;
                        state_in         = S_IDLE;
                     end
                  end else begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = src_idx;
                     state_in        = S_RD_SRC;
                  end
               end
            endcase
         end

         S_RD_SRC: begin
            unique case (act_ff)
               ACT_LOOKUP: begin
                  if (out_free) begin
                     emit                    = 1'b1;
                     emit_data.result_handle = HANDLE_OUT_BITS'(rd_data.handle);
                     state_in                = S_IDLE;
                  end
               end
               ACT_CLOSE: begin
                  if (out_free) begin
                     occ_in[src_idx]           = 1'b0;
                     count_in                  = count_ff - 1'b1;
                     emit                      = 1'b1;
                     emit_data.release_valid   = 1'b1;
                     emit_data.released_handle = HANDLE_OUT_BITS'(rd_data.handle);
                     state_in                  = S_IDLE;
                  end
               end
               ACT_RD_FLAG: begin
                  if (out_free) begin
                     emit               = 1'b1;
                     emit_data.flag_out = rd_data.exec_close;
                     state_in           = S_IDLE;
                  end
               end
               ACT_WR_FLAG: begin
                  if (out_free) begin
                     ram_req.wr_en              = 1'b1;
                     ram_req.wr_addr            = src_idx;
                     ram_req.wr_data.handle     = rd_data.handle;
                     ram_req.wr_data.exec_close = fv_ff;
                     emit                       = 1'b1;
                     state_in                   = S_IDLE;
                  end
               end
               ACT_DUP: begin
                  hsrc_in = rd_data.handle;
                  if (tgt_ff[7]) begin
                     floor_in = '0;
                     grp_in   = '0;
                     state_in = S_SCAN;
                  end else if (!tgt_in_range) begin
                     if (out_free) begin
                        emit             = 1'b1;
                        emit_data.status = ST_BAD_SLOT;
                        state_in         = S_IDLE;
                     end
                  end else if (tgt_ff == src_ff) begin
                     // duplicate onto itself: report only
                     if (out_free) begin
                        emit                    = 1'b1;
                        emit_data.result_slot   = SLOT_OUT_BITS'(tgt_idx);
                        emit_data.result_handle = HANDLE_OUT_BITS'(rd_data.handle);
                        state_in                = S_IDLE;
                     end
                  end else if (occ_ff[tgt_idx]) begin
                     // fetch the handle that the overwrite releases
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = tgt_idx;
                     state_in        = S_RD_TGT;
                  end else if (out_free) begin
                     ram_req.wr_en              = 1'b1;
                     ram_req.wr_addr            = tgt_idx;
                     ram_req.wr_data.handle     = rd_data.handle;
                     ram_req.wr_data.exec_close = 1'b0;
                     occ_in[tgt_idx]            = 1'b1;
                     count_in                   = count_ff + 1'b1;
                     emit                       = 1'b1;
                     emit_data.result_slot      = SLOT_OUT_BITS'(tgt_idx);
                     emit_data.result_handle    = HANDLE_OUT_BITS'(rd_data.handle);
                     emit_data.add_reference    = 1'b1;
                     state_in                   = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_RD_TGT: begin
            if (out_free) begin
               ram_req.wr_en              = 1'b1;
               ram_req.wr_addr            = tgt_idx;
               ram_req.wr_data.handle     = hsrc_ff;
               ram_req.wr_data.exec_close = 1'b0;
               emit                       = 1'b1;
               emit_data.result_slot      = SLOT_OUT_BITS'(tgt_idx);
               emit_data.result_handle    = HANDLE_OUT_BITS'(hsrc_ff);
               emit_data.add_reference    = 1'b1;
               emit_data.release_valid    = 1'b1;
               emit_data.released_handle  = HANDLE_OUT_BITS'(rd_data.handle);
               state_in                   = S_IDLE;
            end
         end

         S_SCAN: begin
            if (scan_found) begin
               if (out_free) begin
                  ram_req.wr_addr            = scan_slot;
                  ram_req.wr_data.exec_close = 1'b0;
                  emit                       = 1'b1;
                  emit_data.result_slot      = SLOT_OUT_BITS'(scan_slot);
                  state_in                   = S_IDLE;
                  if (act_ff == ACT_ALLOC) begin
                     // a zero handle leaves the slot free
                     if (hnd_ff != '0) begin
                        ram_req.wr_en          = 1'b1;
                        ram_req.wr_data.handle = hnd_ff;
                        occ_in[scan_slot]      = 1'b1;
                        count_in               = count_ff + 1'b1;
                     end
                  end else begin
                     ram_req.wr_en           = 1'b1;
                     ram_req.wr_data.handle  = hsrc_ff;
                     occ_in[scan_slot]       = 1'b1;
                     count_in                = count_ff + 1'b1;
                     emit_data.result_handle = HANDLE_OUT_BITS'(hsrc_ff);
                     emit_data.add_reference = 1'b1;
                  end
               end
            end else if (grp_ff == LAST_GROUP) begin
               if (out_free) begin
                  emit             = 1'b1;
                  emit_data.status = ST_FULL;
                  state_in         = S_IDLE;
               end
            end else begin
               grp_in = grp_ff + 1'b1;
            end
         end

         S_SW_RD: begin
            if (occ_ff[idx_ff]) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = idx_ff;
               state_in        = S_SW_CHK;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_SW_END;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_SW_CHK: begin
            // a release is held back until the next one shows it is not the last
            if (!sweep_release || !pend_valid_ff || out_free) begin
               if (sweep_release) begin
                  if (pend_valid_ff) begin
                     emit      = 1'b1;
                     fresh     = 1'b0;
                     emit_data = pend_ff;
                  end
                  occ_in[idx_ff]          = 1'b0;
                  count_in                = count_ff - 1'b1;
                  pend_valid_in           = 1'b1;
                  pend_in                 = '0;
                  pend_in.result_slot     = SLOT_OUT_BITS'(idx_ff);
                  pend_in.release_valid   = 1'b1;
                  pend_in.released_handle = HANDLE_OUT_BITS'(rd_data.handle);
                  pend_in.open_count      = COUNT_OUT_BITS'(count_ff - 1'b1);
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = S_SW_END;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SW_RD;
               end
            end
         end

         S_SW_END: begin
            if (out_free) begin
               emit = 1'b1;
               if (pend_valid_ff) begin
                  fresh          = 1'b0;
                  emit_data      = pend_ff;
                  emit_data.last = 1'b1;
               end
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fresh) begin
         emit_data.open_count = COUNT_OUT_BITS'(count_in);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_data;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      src_ff   <= src_in;
      tgt_ff   <= tgt_in;
      hnd_ff   <= hnd_in;
      fv_ff    <= fv_in;
      hsrc_ff  <= hsrc_in;
      floor_ff <= floor_in;
      grp_ff   <= grp_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
      pend_ff  <= pend_in;
   end

   assign req_ch.ready           = (state_ff == S_IDLE);
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_ff.status;
   assign rsp_ch.result_slot     = rsp_ff.result_slot;
   assign rsp_ch.result_handle   = rsp_ff.result_handle;
   assign rsp_ch.flag_out        = rsp_ff.flag_out;
   assign rsp_ch.add_reference   = rsp_ff.add_reference;
   assign rsp_ch.release_valid   = rsp_ff.release_valid;
   assign rsp_ch.released_handle = rsp_ff.released_handle;
   assign rsp_ch.open_count      = rsp_ff.open_count;
   assign rsp_ch.last            = rsp_ff.last;

endmodule

>>> src/dte_checker.sv
// Port-level assertions of the descriptor table engine and their bind.
`timescale 1ns / 1ps

module dte_checker
   import dte_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [5:0]  rsp_result_slot,
   input logic [15:0] rsp_result_handle,
   input logic        rsp_add_reference,
   input logic        rsp_release_valid,
   input logic [15:0] rsp_released_handle,
   input logic [6:0]  rsp_open_count,
   input logic        rsp_last
);

   // one request at a time: ready drops after each accepted beat
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_slot) && $stable(rsp_result_handle)
         && $stable(rsp_released_handle) && $stable(rsp_last)))
      else $error("stalled response beat changed");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (!rsp_add_reference && !rsp_release_valid && rsp_last))
      else $error("error beat changed the table or was not last");

   a_release_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_release_valid) |-> (rsp_released_handle == '0))
      else $error("released handle without release");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_open_count) <= TABLE_DEPTH))
      else $error("open count beyond table depth");

endmodule

bind descriptor_table_engine dte_checker u_dte_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_status          (rsp_ch.status),
   .rsp_result_slot     (rsp_ch.result_slot),
   .rsp_result_handle   (rsp_ch.result_handle),
   .rsp_add_reference   (rsp_ch.add_reference),
   .rsp_release_valid   (rsp_ch.release_valid),
   .rsp_released_handle (rsp_ch.released_handle),
   .rsp_open_count      (rsp_ch.open_count),
   .rsp_last            (rsp_ch.last)
);
